/* rtl/assert_macros.svh */
// Assertion macros used by the checker file msfc_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/msfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msfc_pkg
// Types, codes and constants of the motor state-feedback controller.
// ----------------------------------------------------------------------------
package msfc_pkg;

    localparam int PULSES_PER_REV = 360;

    // rpm = floor(x / PULSES_PER_REV), x = pulses * 60 < 2**22, by reciprocal
    localparam int RPM_X_W   = 22;
    localparam int RPM_M_W   = 24;
    localparam int RPM_P_W   = RPM_X_W + RPM_M_W;
    localparam int RPM_SHIFT = RPM_X_W + $clog2(PULSES_PER_REV);
    localparam logic [RPM_M_W-1:0] RPM_MULT = RPM_M_W'(
        ((64'd1 << RPM_SHIFT) + 64'(PULSES_PER_REV) - 64'd1) / 64'(PULSES_PER_REV));

    localparam int QUEUE_DEPTH = 2;
    localparam int MOD_STEPS   = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_REF_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_PERIOD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_PERIOD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT     = 3'd6;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_PULSE = 2'd1;
    localparam logic [1:0] KIND_REF   = 2'd2;

    localparam logic EVENT_DUTY  = 1'b0;
    localparam logic EVENT_SPEED = 1'b1;

    localparam logic signed [15:0] RST_REF_GAIN       = 16'sd1376;
    localparam logic signed [15:0] RST_SPEED_GAIN     = 16'sd5428;
    localparam logic signed [15:0] RST_CURRENT_GAIN   = 16'sd57;
    localparam logic [11:0]        RST_CURRENT_OFFSET = 12'd2048;
    localparam logic [9:0]         RST_CONTROL_PERIOD = 10'd10;
    localparam logic [15:0]        RST_SPEED_PERIOD   = 16'd1000;
    localparam logic [15:0]        RST_DUTY_LIMIT     = 16'd4096;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] current_sample;
        logic [11:0] reference_sample;
    } in_t;

    typedef struct packed {
        logic        event_res;
        logic [15:0] duty;
        logic [15:0] speed_rpm;
    } out_t;

    typedef struct packed {
        logic signed [15:0] ref_gain;
        logic signed [15:0] speed_gain;
        logic signed [15:0] current_gain;
        logic [11:0]        current_offset;
        logic [9:0]         control_period;
        logic [15:0]        speed_period;
        logic [15:0]        duty_limit;
    } cfg_t;

    // one queued job for the back end
    typedef struct packed {
        logic        is_speed;
        logic [15:0] pulses;
        logic [11:0] ref_code;
        logic [11:0] mag;
    } entry_t;

endpackage

/* rtl/msfc_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msfc_fifo
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module msfc_fifo #(
    parameter int DEPTH = msfc_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  msfc_pkg::entry_t push_data,
    output logic             full,
    input  logic             pop,
    output msfc_pkg::entry_t pop_data,
    output logic             empty
);
    import msfc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    entry_t          mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [AW:0]     count_reg;
    logic [AW:0]     count_next;

    assign full     = (count_reg == (AW + 1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/msfc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msfc_front
// Accepts items, keeps counters and reference, queues speed and duty jobs.
// ----------------------------------------------------------------------------
module msfc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  msfc_pkg::cfg_t   cfg,
    input  logic             cp_wr,
    input  logic             in_valid,
    output logic             in_ready,
    input  msfc_pkg::in_t    in_data,
    output logic             push,
    output msfc_pkg::entry_t push_data,
    input  logic             full
);
    import msfc_pkg::*;

    logic [15:0] tick_reg;
    logic [15:0] tick_next;
    logic [15:0] pulse_reg;
    logic [15:0] pulse_next;
    logic [11:0] ref_code_reg;
    logic [11:0] ref_code_next;
    logic [9:0]  residue_reg;
    logic [9:0]  residue_next;

    // residue = tick mod control_period, rebuilt after a period write
    logic        mod_busy_reg;
    logic        mod_busy_next;
    logic [3:0]  mod_step_reg;
    logic [3:0]  mod_step_next;
    logic [9:0]  mod_rem_reg;
    logic [9:0]  mod_rem_next;
    logic [15:0] mod_div_reg;
    logic [15:0] mod_div_next;

    logic        accept;
    logic [16:0] tick_inc;
    logic [16:0] sp_eff;
    logic [9:0]  cp_eff;
    logic        speed_due;
    logic [10:0] res_inc;
    logic        ctrl_due;
    logic [12:0] diff;
    logic [12:0] diff_neg;
    logic [10:0] rem_sh;
    logic [10:0] rem_sub;

    assign in_ready = !full && !mod_busy_reg;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        tick_inc  = {1'b0, tick_reg} + 17'd1;
        sp_eff    = (cfg.speed_period == '0) ? 17'h10000 : {1'b0, cfg.speed_period};
        cp_eff    = (cfg.control_period == '0) ? 10'd1 : cfg.control_period;
        speed_due = (tick_inc >= sp_eff);
        res_inc   = {1'b0, residue_reg} + 11'd1;
        ctrl_due  = (res_inc >= {1'b0, cp_eff});
        diff      = {1'b0, in_data.current_sample} - {1'b0, cfg.current_offset};
        diff_neg  = 13'd0 - diff;
        rem_sh    = {mod_rem_reg, mod_div_reg[15]};
        rem_sub   = rem_sh - {1'b0, cp_eff};

        push_data.is_speed = 1'b0;
        push_data.pulses   = pulse_reg;
        push_data.ref_code = ref_code_reg;
        push_data.mag      = diff[12] ? diff_neg[11:0] : diff[11:0];

        push          = 1'b0;
        tick_next     = tick_reg;
        pulse_next    = pulse_reg;
        ref_code_next = ref_code_reg;
        residue_next  = residue_reg;

        if (accept)
        begin
            case (in_data.kind)
                KIND_TICK:
                begin
                    if (speed_due)
                    begin
                        push_data.is_speed = 1'b1;
                        push               = 1'b1;
                        tick_next          = '0;
                        pulse_next         = '0;
                        residue_next       = '0;
                    end
                    else
                    begin
                        tick_next    = tick_inc[15:0];
                        residue_next = ctrl_due ? '0 : res_inc[9:0];
                        push         = ctrl_due;
                    end
                end
                KIND_PULSE:
                begin
                    if (pulse_reg != 16'hFFFF)
                    begin
                        pulse_next = pulse_reg + 16'd1;
                    end
                end
                KIND_REF:
                begin
                    ref_code_next = in_data.reference_sample;
                end
                default:
                begin
                end
            endcase
        end

        mod_busy_next = mod_busy_reg;
        mod_step_next = mod_step_reg;
        mod_rem_next  = mod_rem_reg;
        mod_div_next  = mod_div_reg;
        if (cp_wr)
        begin
            mod_busy_next = 1'b1;
            mod_step_next = '0;
            mod_rem_next  = '0;
            mod_div_next  = tick_reg;
        end
        else if (mod_busy_reg)
        begin
            mod_rem_next  = (rem_sh >= {1'b0, cp_eff}) ? rem_sub[9:0] : rem_sh[9:0];
            mod_div_next  = {mod_div_reg[14:0], 1'b0};
            mod_step_next = mod_step_reg + 4'd1;
            if (mod_step_reg == 4'(MOD_STEPS - 1))
            begin
                mod_busy_next = 1'b0;
                residue_next  = mod_rem_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            pulse_reg    <= '0;
            ref_code_reg <= '0;
            residue_reg  <= '0;
            mod_busy_reg <= 1'b0;
            mod_step_reg <= '0;
        end
        else
        begin
            tick_reg     <= tick_next;
            pulse_reg    <= pulse_next;
            ref_code_reg <= ref_code_next;
            residue_reg  <= residue_next;
            mod_busy_reg <= mod_busy_next;
            mod_step_reg <= mod_step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mod_rem_reg <= mod_rem_next;
        mod_div_reg <= mod_div_next;
    end

endmodule

/* rtl/msfc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msfc_back
// Multiply stage and output register: rpm measurement and duty law.
// ----------------------------------------------------------------------------
module msfc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  msfc_pkg::cfg_t   cfg,
    input  msfc_pkg::entry_t head,
    input  logic             empty,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output msfc_pkg::out_t   out_data
);
    import msfc_pkg::*;

    logic                      s1_valid_reg;
    logic                      s1_speed_reg;
    logic [RPM_P_W-1:0]        s1_rpm_prod_reg;
    logic signed [28:0]        s1_ref_prod_reg;
    logic signed [32:0]        s1_spd_prod_reg;
    logic signed [28:0]        s1_cur_prod_reg;

    logic                      out_valid_reg;
    out_t                      out_data_reg;
    out_t                      out_data_next;
    logic [15:0]               speed_value_reg;

    logic                      s1_move;
    logic                      s1_free;
    logic [RPM_X_W-1:0]        rpm_x;
    logic [RPM_P_W-1:0]        rpm_prod;
    logic signed [28:0]        ref_prod;
    logic signed [32:0]        spd_prod;
    logic signed [28:0]        cur_prod;
    logic [RPM_P_W-1:0]        rpm_full;
    logic [15:0]               rpm_sat;
    logic signed [34:0]        acc;
    logic signed [22:0]        quot;
    logic signed [23:0]        quot_inc;
    logic [15:0]               duty_sat;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // speed value is read by the next job, so nothing is popped as a speed job moves on
    assign s1_move = s1_valid_reg && (!out_valid_reg || out_ready);
    assign s1_free = !s1_valid_reg || (s1_move && !s1_speed_reg);
    assign pop     = !empty && s1_free;

    always_comb
    begin
        rpm_x    = {head.pulses, 6'd0} - {4'd0, head.pulses, 2'd0};
        rpm_prod = RPM_P_W'(rpm_x) * RPM_P_W'(RPM_MULT);
        ref_prod = 29'($signed(cfg.ref_gain)) * 29'($signed({1'b0, head.ref_code}));
        spd_prod = 33'($signed(cfg.speed_gain)) * 33'($signed({1'b0, speed_value_reg}));
        cur_prod = 29'($signed(cfg.current_gain)) * 29'($signed({1'b0, head.mag}));

        rpm_full = s1_rpm_prod_reg >> RPM_SHIFT;
        rpm_sat  = (|rpm_full[RPM_P_W-1:16]) ? 16'hFFFF : rpm_full[15:0];

        acc      = 35'(s1_ref_prod_reg) + 35'(s1_spd_prod_reg) + 35'(s1_cur_prod_reg);
        quot     = 23'(acc >>> 12);
        quot_inc = 24'(quot) + 24'sd1;
        if (quot_inc[23])
        begin
            duty_sat = '0;
        end
        else if (quot_inc[22:0] > {7'd0, cfg.duty_limit})
        begin
            duty_sat = cfg.duty_limit;
        end
        else
        begin
            duty_sat = quot_inc[15:0];
        end

        if (s1_speed_reg)
        begin
            out_data_next.event_res = EVENT_SPEED;
            out_data_next.duty      = '0;
            out_data_next.speed_rpm = rpm_sat;
        end
        else
        begin
            out_data_next.event_res = EVENT_DUTY;
            out_data_next.duty      = duty_sat;
            out_data_next.speed_rpm = speed_value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            speed_value_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (s1_move && s1_speed_reg)
            begin
                speed_value_reg <= rpm_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_speed_reg    <= head.is_speed;
            s1_rpm_prod_reg <= rpm_prod;
            s1_ref_prod_reg <= ref_prod;
            s1_spd_prod_reg <= spd_prod;
            s1_cur_prod_reg <= cur_prod;
        end
        if (s1_move)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

/* rtl/motor_state_feedback_controller_core.sv */
`timescale 1ns / 1ps
// A tick result goes through the job queue, multiply stage and output register.
// Throughput: one item per cycle while in_ready is high; a speed job holds the
// next pop back. A control_period write holds in_ready low for the residue divider.
// Reset (rst_n, async, active low): counters, speed and reference clear,
// registers return to their defaults, queue and output empty.
// ----------------------------------------------------------------------------
// motor_state_feedback_controller_core
// Motor speed measurement and state-feedback duty controller, top level.
// ----------------------------------------------------------------------------
module motor_state_feedback_controller_core #(
    parameter int QUEUE_DEPTH = msfc_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  msfc_pkg::in_t                    in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output msfc_pkg::out_t                   out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [msfc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msfc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import msfc_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   cp_wr;
    logic   push;
    entry_t push_data;
    logic   full;
    logic   pop;
    entry_t head;
    logic   empty;

    assign cfg_ready = 1'b1;
    assign cp_wr     = cfg_valid && (cfg_index == REG_CONTROL_PERIOD);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_REF_GAIN:       cfg_next.ref_gain       = cfg_data;
                REG_SPEED_GAIN:     cfg_next.speed_gain     = cfg_data;
                REG_CURRENT_GAIN:   cfg_next.current_gain   = cfg_data;
                REG_CURRENT_OFFSET: cfg_next.current_offset = cfg_data[11:0];
                REG_CONTROL_PERIOD: cfg_next.control_period = cfg_data[9:0];
                REG_SPEED_PERIOD:   cfg_next.speed_period   = cfg_data;
                REG_DUTY_LIMIT:     cfg_next.duty_limit     = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ref_gain       <= RST_REF_GAIN;
            cfg_reg.speed_gain     <= RST_SPEED_GAIN;
            cfg_reg.current_gain   <= RST_CURRENT_GAIN;
            cfg_reg.current_offset <= RST_CURRENT_OFFSET;
            cfg_reg.control_period <= RST_CONTROL_PERIOD;
            cfg_reg.speed_period   <= RST_SPEED_PERIOD;
            cfg_reg.duty_limit     <= RST_DUTY_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    msfc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cp_wr     (cp_wr),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    msfc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (head),
        .empty     (empty)
    );

    msfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* rtl/msfc_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// msfc_checker
// Port-level checks of the controller top level, attached by bind.
// ----------------------------------------------------------------------------
module msfc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input msfc_pkg::out_t                   out_data,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [msfc_pkg::CFG_IDX_W-1:0]   cfg_index
);
    import msfc_pkg::*;

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `ASSERT_IMPLIES(a_speed_duty_zero, clk, rst_n, out_valid && (out_data.event_res == EVENT_SPEED), out_data.duty == 16'd0)
    `ASSERT_NEXT(a_period_wr_stall, clk, rst_n, cfg_valid && cfg_ready && (cfg_index == REG_CONTROL_PERIOD), !in_ready)

endmodule

bind motor_state_feedback_controller_core msfc_checker u_checker (.*);
